>>> src/swc_pkg.sv
// shared constants, types and functions for the swirl warp coordinate block
`default_nettype none
package swc_pkg;

	localparam int CoordBits       = 12;
	localparam int CordicStagesDef = 16;
	localparam int DimBits   = 13;
	localparam int TwistBits = 17;
	localparam int CfgIdxBits = 2;
	localparam int CfgDataBits = 17;

	localparam logic [CfgIdxBits-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CfgIdxBits-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CfgIdxBits-1:0] REG_TWIST  = 2'd2;

	localparam logic [DimBits-1:0]   WidthReset  = 13'd640;
	localparam logic [DimBits-1:0]   HeightReset = 13'd480;
	localparam logic [TwistBits-1:0] TwistReset  = 17'h1CCCD;

	// offsets are at most 4096 in magnitude: 14 bit signed
	localparam int OffBits = 14;
	// sum of squares below 2^25
	localparam int SsqBits = 26;
	// radius in Q16, below 2^29
	localparam int RadBits = 29;
	// remainder of the root extraction
	localparam int RemBits = 32;
	// angle in Q32 radians: radius times twist, 47 bit signed
	localparam int AngBits = 47;
	localparam int CordBits = 20;

	localparam logic signed [AngBits-1:0] TwoPi  = 47'sd26986075409;
	localparam logic signed [AngBits-1:0] Pi     = 47'sd13493037705;
	localparam logic signed [AngBits-1:0] HalfPi = 47'sd6746518852;
	localparam logic signed [CordBits-1:0] CordicK = 20'sd39796;

	function automatic logic signed [CordBits-1:0] atan_q16(input int i);
		logic signed [CordBits-1:0] v;
		case (i)
			0: v = 20'sd51472;
			1: v = 20'sd30386;
			2: v = 20'sd16055;
			3: v = 20'sd8150;
			4: v = 20'sd4091;
			5: v = 20'sd2047;
			6: v = 20'sd1024;
			7: v = 20'sd512;
			8: v = 20'sd256;
			9: v = 20'sd128;
			10: v = 20'sd64;
			11: v = 20'sd32;
			12: v = 20'sd16;
			13: v = 20'sd8;
			14: v = 20'sd4;
			15: v = 20'sd2;
			16: v = 20'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	// payload carried alongside each cell stage
	typedef struct packed {
		logic signed [OffBits-1:0] x;
		logic signed [OffBits-1:0] y;
		logic [DimBits-1:0]        wd;
		logic [DimBits-1:0]        ht;
	} coord_t;

	typedef struct packed {
		logic signed [CordBits-1:0] cx;
		logic signed [CordBits-1:0] cy;
		logic signed [CordBits-1:0] cz;
		logic                       neg;
	} rot_t;

endpackage
`default_nettype wire

>>> src/swc_sqrt_cell.sv
// one cell of the digit-by-digit square root chain, two result bits per cell
`default_nettype none
module swc_sqrt_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          vld,
	input  wire [swc_pkg::SsqBits-1:0]   ssq,
	input  wire [swc_pkg::RemBits-1:0]   rem,
	input  wire [swc_pkg::RadBits-1:0]   root,
	input  wire [5:0]                    k0,
	input  wire swc_pkg::coord_t         crd,
	input  wire [swc_pkg::TwistBits-1:0] twist,
	output logic                         vld_q,
	output logic [swc_pkg::SsqBits-1:0]  ssq_q,
	output logic [swc_pkg::RemBits-1:0]  rem_q,
	output logic [swc_pkg::RadBits-1:0]  root_q,
	output swc_pkg::coord_t              crd_q,
	output logic [swc_pkg::TwistBits-1:0] twist_q
);
	import swc_pkg::*;

	logic [RemBits-1:0] r0, r1, t0, t1;
	logic [RadBits-1:0] q0, q1;
	logic [1:0] p0, p1;

	function automatic logic [1:0] pair_of(input logic [SsqBits-1:0] s, input logic [5:0] k);
		logic [1:0] p;
		logic [5:0] sh;
		p  = 2'd0;
		sh = 6'd32 - {k[4:0], 1'b0};
		if (k < 6'd17 && sh < 6'(SsqBits))
			p = 2'(s >> sh);
		return p;
	endfunction

	always_comb begin
		p0 = pair_of(ssq, k0);
		r0 = {rem[RemBits-3:0], p0};
		t0 = {1'b0, root, 2'b01};
		if (r0 >= t0) begin
			r0 = r0 - t0;
			q0 = {root[RadBits-2:0], 1'b1};
		end else begin
			q0 = {root[RadBits-2:0], 1'b0};
		end
		p1 = pair_of(ssq, k0 + 6'd1);
		r1 = {r0[RemBits-3:0], p1};
		t1 = {1'b0, q0, 2'b01};
		if (r1 >= t1) begin
			r1 = r1 - t1;
			q1 = {q0[RadBits-2:0], 1'b1};
		end else begin
			q1 = {q0[RadBits-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else vld_q <= vld;
	end

	always_ff @(posedge clk) begin
		ssq_q   <= ssq;
		rem_q   <= r1;
		root_q  <= q1;
		crd_q   <= crd;
		twist_q <= twist;
	end

endmodule
`default_nettype wire

>>> src/swc_cordic_cell.sv
// one rotation-mode cordic cell
`default_nettype none
module swc_cordic_cell #(
	parameter int Stage = 0
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             vld,
	input  wire swc_pkg::rot_t   rot,
	input  wire swc_pkg::coord_t crd,
	output logic            vld_q,
	output swc_pkg::rot_t   rot_q,
	output swc_pkg::coord_t crd_q
);
	import swc_pkg::*;

	localparam logic signed [CordBits-1:0] Atan = atan_q16(Stage);
	logic signed [CordBits-1:0] dx, dy;
	rot_t nxt;

	always_comb begin
		dx = rot.cy >>> Stage;
		dy = rot.cx >>> Stage;
		nxt = rot;
		if (!rot.cz[CordBits-1]) begin
			nxt.cx = rot.cx - dx;
			nxt.cy = rot.cy + dy;
			nxt.cz = rot.cz - Atan;
		end else begin
			nxt.cx = rot.cx + dx;
			nxt.cy = rot.cy - dy;
			nxt.cz = rot.cz + Atan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else vld_q <= vld;
	end

	always_ff @(posedge clk) begin
		rot_q <= nxt;
		crd_q <= crd;
	end

endmodule
`default_nettype wire

>>> src/swirl_warp_coordinate.sv
// swirl warp coordinate generator: root cells, angle fold, cordic cells, output
// channel   | signals                                  | direction
// command   | start, busy, dest_col, dest_row          | in
// result    | strobe, src_col, src_row, inside_res     | out
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | in
// one request per clock; the pipeline is 2 input stages, 17 root cells, 4 angle stages,
// CORDIC_STAGES cordic cells and 3 output stages.
// busy is always low; the cell chains advance every cycle.
// reset clears all stage valid bits and loads the config registers; data registers are not reset.
// the receiver cannot stall: strobe lasts one cycle.
`default_nettype none
module swirl_warp_coordinate #(
	parameter int CORDIC_STAGES = swc_pkg::CordicStagesDef
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire [swc_pkg::CoordBits-1:0]     dest_col,
	input  wire [swc_pkg::CoordBits-1:0]     dest_row,
	output logic                             strobe,
	output logic [swc_pkg::CoordBits-1:0]    src_col,
	output logic [swc_pkg::CoordBits-1:0]    src_row,
	output logic                             inside_res,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [swc_pkg::CfgIdxBits-1:0]    cfg_index,
	input  wire [swc_pkg::CfgDataBits-1:0]   cfg_data
);
	import swc_pkg::*;

	localparam int SqCells = 17;
	localparam int MulBits = OffBits + CordBits + 1;
	localparam int SumBits = MulBits + 2;
	localparam int QBits = 14;

	logic [DimBits-1:0]   width_q, height_q;
	logic [TwistBits-1:0] twist_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthReset;
			height_q <= HeightReset;
			twist_q  <= TwistReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[DimBits-1:0];
				REG_HEIGHT: height_q <= cfg_data[DimBits-1:0];
				REG_TWIST:  twist_q  <= cfg_data[TwistBits-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: offsets from centre, truncated toward zero
	logic accept;
	logic signed [OffBits:0] dx2, dy2;
	logic signed [OffBits-1:0] ox, oy;
	logic vld_s1;
	coord_t crd_s1;
	logic [TwistBits-1:0] tw_s1;
	assign accept = start && !busy;

	always_comb begin
		dx2 = $signed({1'b0, 14'(dest_col)} <<< 1) - $signed({2'b00, width_q});
		dy2 = $signed({1'b0, 14'(dest_row)} <<< 1) - $signed({2'b00, height_q});
		ox = OffBits'((dx2 + (dx2[OffBits] ? 15'sd1 : 15'sd0)) >>> 1);
		oy = OffBits'((dy2 + (dy2[OffBits] ? 15'sd1 : 15'sd0)) >>> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= accept;
	end
	always_ff @(posedge clk) begin
		crd_s1 <= '{x: ox, y: oy, wd: width_q, ht: height_q};
		tw_s1  <= twist_q;
	end

	// stage 2: squares
	logic vld_s2;
	coord_t crd_s2;
	logic [TwistBits-1:0] tw_s2;
	logic [SsqBits-1:0] ssq_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		crd_s2 <= crd_s1;
		tw_s2  <= tw_s1;
		ssq_s2 <= SsqBits'(crd_s1.x * crd_s1.x) + SsqBits'(crd_s1.y * crd_s1.y);
	end

	// square root chain: 34 digits, two per cell (the trailing digit pairs are zero)
	logic                 sv  [SqCells+1];
	logic [SsqBits-1:0]   ss  [SqCells+1];
	logic [RemBits-1:0]   sr  [SqCells+1];
	logic [RadBits-1:0]   sq  [SqCells+1];
	coord_t               sc  [SqCells+1];
	logic [TwistBits-1:0] st  [SqCells+1];

	assign sv[0] = vld_s2;
	assign ss[0] = ssq_s2;
	assign sr[0] = '0;
	assign sq[0] = '0;
	assign sc[0] = crd_s2;
	assign st[0] = tw_s2;

	// the chain handles 34 digits; one extra leading zero pair is harmless
	for (genvar g = 0; g < SqCells; g++) begin : g_sqrt
		swc_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.vld(sv[g]), .ssq(ss[g]), .rem(sr[g]), .root(sq[g]),
			.k0(6'(2*g) - 6'd1), .crd(sc[g]), .twist(st[g]),
			.vld_q(sv[g+1]), .ssq_q(ss[g+1]), .rem_q(sr[g+1]), .root_q(sq[g+1]),
			.crd_q(sc[g+1]), .twist_q(st[g+1])
		);
	end

	// angle stage a: radius times twist
	logic vld_a1, vld_a2, vld_a3, vld_a4;
	coord_t crd_a1, crd_a2, crd_a3, crd_a4;
	logic signed [AngBits-1:0] ang_a1, ang_a2, ang_a3;
	logic signed [QBits-1:0] q_a1;
	logic neg_a3;
	logic signed [CordBits-1:0] z_a4;
	logic neg_a4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a1 <= 1'b0; vld_a2 <= 1'b0; vld_a3 <= 1'b0; vld_a4 <= 1'b0;
		end else begin
			vld_a1 <= sv[SqCells]; vld_a2 <= vld_a1; vld_a3 <= vld_a2; vld_a4 <= vld_a3;
		end
	end

	// reduction: quotient estimate by reciprocal of 2*pi, then correction
	// estimate from the top angle bits is within one of the true quotient
	localparam logic [14:0] InvTwoPi = 15'd10430; // round(2^16/(2*pi))
	logic signed [AngBits-1:0] ang_m;
	logic signed [AngBits-25:0] ang_hi;
	logic signed [AngBits-10:0] qprod;
	logic signed [AngBits-1:0] red, red2;

	always_comb begin
		ang_m = AngBits'($signed({1'b0, sq[SqCells]}) * $signed(st[SqCells]));
		ang_hi = ang_a1[AngBits-1:24];
		qprod = ang_hi * $signed({1'b0, InvTwoPi});
	end

	always_ff @(posedge clk) begin
		crd_a1 <= sc[SqCells];
		ang_a1 <= ang_m;
		crd_a2 <= crd_a1;
		ang_a2 <= ang_a1;
		q_a1   <= QBits'(qprod >>> 24);
	end

	// remainder after floor quotient; fix up within one step either way
	always_comb begin
		red = ang_a2 - AngBits'(q_a1 * TwoPi);
		if (red < 0) red = red + TwoPi;
		else if (red >= TwoPi) red = red - TwoPi;
		if (red > Pi) red = red - TwoPi;
	end

	always_ff @(posedge clk) begin
		crd_a3 <= crd_a2;
		ang_a3 <= red;
	end

	always_comb begin
		red2 = ang_a3;
		neg_a3 = 1'b0;
		if (ang_a3 > HalfPi) begin
			red2 = ang_a3 - Pi;
			neg_a3 = 1'b1;
		end else if (ang_a3 < -HalfPi) begin
			red2 = ang_a3 + Pi;
			neg_a3 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		crd_a4 <= crd_a3;
		z_a4   <= CordBits'(red2 >>> 16);
		neg_a4 <= neg_a3;
	end

	// cordic chain
	logic   cv [CORDIC_STAGES+1];
	rot_t   cr [CORDIC_STAGES+1];
	coord_t cc [CORDIC_STAGES+1];
	assign cv[0] = vld_a4;
	assign cr[0] = '{cx: CordicK, cy: '0, cz: z_a4, neg: neg_a4};
	assign cc[0] = crd_a4;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		swc_cordic_cell #(.Stage(g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.vld(cv[g]), .rot(cr[g]), .crd(cc[g]),
			.vld_q(cv[g+1]), .rot_q(cr[g+1]), .crd_q(cc[g+1])
		);
	end

	// output stage 1: sign fix and four products
	logic vld_o1, vld_o2;
	coord_t crd_o1, crd_o2;
	logic signed [CordBits-1:0] cs, sn;
	logic signed [MulBits-1:0] xc_o1, ys_o1, xs_o1, yc_o1;
	always_comb begin
		cs = cr[CORDIC_STAGES].neg ? -cr[CORDIC_STAGES].cx : cr[CORDIC_STAGES].cx;
		sn = cr[CORDIC_STAGES].neg ? -cr[CORDIC_STAGES].cy : cr[CORDIC_STAGES].cy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o1 <= 1'b0; vld_o2 <= 1'b0;
		end else begin
			vld_o1 <= cv[CORDIC_STAGES]; vld_o2 <= vld_o1;
		end
	end

	always_ff @(posedge clk) begin
		crd_o1 <= cc[CORDIC_STAGES];
		xc_o1 <= MulBits'(cc[CORDIC_STAGES].x * cs);
		ys_o1 <= MulBits'(cc[CORDIC_STAGES].y * sn);
		xs_o1 <= MulBits'(cc[CORDIC_STAGES].x * sn);
		yc_o1 <= MulBits'(cc[CORDIC_STAGES].y * cs);
	end

	// output stage 2: sums, truncated toward zero
	logic signed [SumBits-1:0] sc_sum, sr_sum;
	logic signed [SumBits-17:0] col_o2, row_o2;
	always_comb begin
		sc_sum = $signed({1'b0, crd_o1.wd, 15'd0}) + SumBits'(xc_o1) - SumBits'(ys_o1);
		sr_sum = $signed({1'b0, crd_o1.ht, 15'd0}) + SumBits'(xs_o1) + SumBits'(yc_o1);
	end

	always_ff @(posedge clk) begin
		crd_o2 <= crd_o1;
		col_o2 <= (SumBits-16)'((sc_sum + (sc_sum[SumBits-1] ? SumBits'(65535) : '0)) >>> 16);
		row_o2 <= (SumBits-16)'((sr_sum + (sr_sum[SumBits-1] ? SumBits'(65535) : '0)) >>> 16);
	end

	// output stage 3: range check
	logic in_chk;
	localparam logic signed [SumBits-17:0] CoordMax = (SumBits-16)'((1 << CoordBits) - 1);
	always_comb begin
		in_chk = !col_o2[SumBits-17] && !row_o2[SumBits-17]
			&& col_o2 < $signed({1'b0, crd_o2.wd}) && row_o2 < $signed({1'b0, crd_o2.ht})
			&& col_o2 <= CoordMax && row_o2 <= CoordMax;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= vld_o2;
	end
	always_ff @(posedge clk) begin
		src_col    <= in_chk ? CoordBits'(col_o2) : '0;
		src_row    <= in_chk ? CoordBits'(row_o2) : '0;
		inside_res <= in_chk;
	end

	a_out_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !inside_res |-> src_col == '0 && src_row == '0)
		else $error("outside result not zeroed");
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		vld_o2 |=> strobe)
		else $error("chain valid lost");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == REG_WIDTH |=> width_q == $past(cfg_data[DimBits-1:0]))
		else $error("width write lost");

endmodule
`default_nettype wire
